/* hdl/mlfq_pkg.sv */
package mlfq_pkg;

  typedef enum logic [1:0] {
    FN_SPAWN    = 2'd0,
    FN_DISPATCH = 2'd1,
    FN_REPORT   = 2'd2,
    FN_WAKE     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OC_TERMINATED = 2'd0,
    OC_BLOCKED    = 2'd1,
    OC_WHOLE      = 2'd2,
    OC_PART       = 2'd3
  } outcome_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SPAWN = 8'b0000_0010,
    S_BCHK  = 8'b0000_0100,
    S_BWAIT = 8'b0000_1000,
    S_SEL   = 8'b0001_0000,
    S_PWAIT = 8'b0010_0000,
    S_RPT   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  // Fixed queue numbers: real-time, blocked; user levels follow.
  localparam int QRT  = 0;
  localparam int QBLK = 1;

  localparam logic [29:0] QUANTUM_RESET = 30'd10000000;

endpackage

/* hdl/mlfq_scheduler_active_expired.sv */
// Hardware task scheduler with a real-time queue, two banks (active and expired) of
// LEVELS user queues, and a blocked queue, all kept in one shared queue memory. Each
// item is taken only while the block is idle and gives exactly one result item. A
// spawn checks one task id per cycle, up to MAX_TASKS ids, until one is free. A
// dispatch walks the blocked queue, then pops the served queue, first swapping the
// banks if the real-time queue and active bank are empty; the single read port of
// the queue memory is used once per blocked entry and once for the pop.
// The base quantum is written through the cfg channel while the block is idle.
module mlfq_scheduler_active_expired import mlfq_pkg::*; #(
  parameter int MAX_TASKS = 18,
  parameter int LEVELS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [29:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [4:0]  task_id_i,
  input  logic        real_time_i,
  input  logic [2:0]  start_level_i,
  input  logic [1:0]  outcome_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [4:0]  result_id_o,
  output logic [2:0]  level_o,
  output logic [29:0] quantum_o,
  output logic        swapped_o,
  output logic [4:0]  woken_moved_o
);

  localparam int NQ    = 2 + 2 * LEVELS;
  localparam int QW    = $clog2(NQ);
  localparam int SW    = $clog2(MAX_TASKS + 1);
  localparam int IXW   = $clog2(MAX_TASKS);
  localparam int LVW   = $clog2(LEVELS + 1);
  localparam int DEPTH = NQ * MAX_TASKS;
  localparam int AW    = $clog2(DEPTH);

  state_e state_q, state_d;

  logic [29:0] base_q;

  // Per-task flags.
  logic [MAX_TASKS-1:0] in_use_q, is_rt_q, woken_q, run_q, blk_q;
  logic [LVW-1:0]       tlvl_q [MAX_TASKS];
  logic [SW-1:0]        last_id_q;
  logic                 bank_q;

  // Queue control and storage.
  logic [SW-1:0] head_q [NQ];
  logic [SW-1:0] cnt_q  [NQ];
  logic [SW-1:0] mem_q  [DEPTH];
  logic [SW-1:0] rdata_q;

  // Captured item.
  func_e           func_q;
  logic [4:0]      tid_q;
  logic            rt_in_q;
  logic [2:0]      sl_q;
  outcome_e        oc_q;

  // Sequencer counters.
  logic [SW-1:0] cand_q, k_q, nblk_q;

  // Pending result.
  logic          res_ok_q, res_swp_q;
  logic [SW-1:0] res_id_q, res_mov_q;
  logic [LVW-1:0] res_lvl_q;

  // Output register.
  logic        out_valid_q, out_ok_q, out_swp_q;
  logic [4:0]  out_id_q, out_mov_q;
  logic [2:0]  out_lvl_q;
  logic [29:0] out_quant_q;

  // Queue port controls.
  logic          push_en, pop_en;
  logic [QW-1:0] push_qi, pop_qi;
  logic [SW-1:0] push_id;
  logic [AW-1:0] waddr, raddr;
  logic [SW:0]   tail_sum;

  // Decode helpers.
  logic           tid_ok;
  logic [IXW-1:0] tix, cix, bix;
  logic [LVW-1:0] sl_clamp, rpt_lvl;
  logic           lvl_found;
  logic [LVW-1:0] lvl_first;

  function automatic logic [QW-1:0] lvq(input logic bank, input logic [LVW-1:0] l);
    return QW'(2 + (bank ? LEVELS : 0) + int'(l) - 1);
  endfunction

  function automatic logic task_id_ok(input logic [4:0] t);
    return (int'(t) >= 1) && (int'(t) <= MAX_TASKS);
  endfunction

  assign tid_ok = (task_id_ok(tid_q));

  assign tix = IXW'(int'(tid_q) - 1);
  assign cix = IXW'(int'(cand_q) - 1);
  assign bix = IXW'(int'(rdata_q) - 1);

  always_comb begin
    if (int'(sl_q) < 1) begin
      sl_clamp = LVW'(1);
    end else if (int'(sl_q) > LEVELS) begin
      sl_clamp = LVW'(LEVELS);
    end else begin
      sl_clamp = LVW'(sl_q);
    end
  end

  // Level a requeued user task enters.
  always_comb begin
    rpt_lvl = (tlvl_q[tix] == '0) ? LVW'(1) : tlvl_q[tix];
    if (oc_q == OC_WHOLE && int'(rpt_lvl) < LEVELS) begin
      rpt_lvl = rpt_lvl + LVW'(1);
    end
  end

  // Lowest-numbered (highest-priority) non-empty level of the active bank.
  always_comb begin
    lvl_found = 1'b0;
    lvl_first = '0;
    for (int i = LEVELS; i >= 1; i--) begin
      if (cnt_q[lvq(bank_q, LVW'(i))] != '0) begin
        lvl_found = 1'b1;
        lvl_first = LVW'(i);
      end
    end
  end

  // Queue push and pop requests, one of each at most per cycle.
  always_comb begin
    push_en = 1'b0;
    push_qi = '0;
    push_id = '0;
    pop_en  = 1'b0;
    pop_qi  = '0;
    unique case (state_q)
      S_SPAWN: begin
        if (k_q != SW'(MAX_TASKS) && !in_use_q[cix]) begin
          push_en = 1'b1;
          push_id = cand_q;
          push_qi = rt_in_q ? QW'(QRT) : lvq(bank_q, sl_clamp);
        end
      end
      S_BCHK: begin
        if (k_q != nblk_q) begin
          pop_en = 1'b1;
          pop_qi = QW'(QBLK);
        end
      end
      S_BWAIT: begin
        push_en = 1'b1;
        push_id = rdata_q;
        push_qi = woken_q[bix] ? lvq(bank_q, LVW'(1)) : QW'(QBLK);
      end
      S_SEL: begin
        if (cnt_q[QRT] != '0) begin
          pop_en = 1'b1;
          pop_qi = QW'(QRT);
        end else if (lvl_found) begin
          pop_en = 1'b1;
          pop_qi = lvq(bank_q, lvl_first);
        end
      end
      S_RPT: begin
        if (func_q == FN_REPORT && tid_ok && in_use_q[tix] && run_q[tix]
            && oc_q != OC_TERMINATED) begin
          push_en = 1'b1;
          push_id = SW'(tid_q);
          if (is_rt_q[tix]) begin
            push_qi = QW'(QRT);
          end else if (oc_q == OC_BLOCKED) begin
            push_qi = QW'(QBLK);
          end else begin
            push_qi = lvq((oc_q == OC_WHOLE) ? ~bank_q : bank_q, rpt_lvl);
          end
        end
      end
      default: ;
    endcase
  end

  assign tail_sum = {1'b0, head_q[push_qi]} + {1'b0, cnt_q[push_qi]};
  always_comb begin
    logic [SW:0] t;
    t = (tail_sum >= (SW+1)'(MAX_TASKS)) ? tail_sum - (SW+1)'(MAX_TASKS) : tail_sum;
    waddr = AW'(int'(push_qi) * MAX_TASKS + int'(t));
  end
  assign raddr = AW'(int'(pop_qi) * MAX_TASKS + int'(head_q[pop_qi]));

  always_ff @(posedge clk_i) begin
    if (push_en && cnt_q[push_qi] < SW'(MAX_TASKS)) begin
      mem_q[waddr] <= push_id;
    end
    rdata_q <= mem_q[raddr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (func_e'(func_i))
            FN_SPAWN:    state_d = S_SPAWN;
            FN_DISPATCH: state_d = S_BCHK;
            default:     state_d = S_RPT;
          endcase
        end
      end
      S_SPAWN: begin
        if (k_q == SW'(MAX_TASKS) || !in_use_q[cix]) state_d = S_DONE;
      end
      S_BCHK:  state_d = (k_q == nblk_q) ? S_SEL : S_BWAIT;
      S_BWAIT: state_d = S_BCHK;
      S_SEL: begin
        if (pop_en) begin
          state_d = S_PWAIT;
        end else if (res_swp_q) begin
          state_d = S_DONE;
        end
      end
      S_PWAIT: state_d = S_DONE;
      S_RPT:   state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= QUANTUM_RESET;
      in_use_q    <= '0;
      is_rt_q     <= '0;
      woken_q     <= '0;
      run_q       <= '0;
      blk_q       <= '0;
      last_id_q   <= '0;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) tlvl_q[i] <= '0;
      for (int i = 0; i < NQ; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && state_q == S_IDLE) base_q <= cfg_data_i;

      if (pop_en) begin
        head_q[pop_qi] <= (head_q[pop_qi] == SW'(MAX_TASKS - 1)) ? '0
                          : head_q[pop_qi] + SW'(1);
        cnt_q[pop_qi]  <= cnt_q[pop_qi] - SW'(1);
      end
      if (push_en && cnt_q[push_qi] < SW'(MAX_TASKS)) begin
        cnt_q[push_qi] <= cnt_q[push_qi] + SW'(1);
      end

      // A new result loads the output register once the previous one is gone.
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_SPAWN: begin
          if (!(k_q == SW'(MAX_TASKS)) && !in_use_q[cix]) begin
            in_use_q[cix] <= 1'b1;
            woken_q[cix]  <= 1'b0;
            run_q[cix]    <= 1'b0;
            blk_q[cix]    <= 1'b0;
            is_rt_q[cix]  <= rt_in_q;
            tlvl_q[cix]   <= rt_in_q ? '0 : sl_clamp;
            last_id_q     <= cand_q;
          end
        end
        S_BWAIT: begin
          if (woken_q[bix]) begin
            woken_q[bix] <= 1'b0;
            blk_q[bix]   <= 1'b0;
            tlvl_q[bix]  <= LVW'(1);
          end
        end
        S_SEL: begin
          if (!pop_en && !res_swp_q) bank_q <= ~bank_q;
        end
        S_PWAIT: run_q[bix] <= 1'b1;
        S_RPT: begin
          if (func_q == FN_REPORT && tid_ok && in_use_q[tix] && run_q[tix]) begin
            run_q[tix] <= 1'b0;
            if (oc_q == OC_TERMINATED) begin
              in_use_q[tix] <= 1'b0;
              woken_q[tix]  <= 1'b0;
              blk_q[tix]    <= 1'b0;
            end else if (!is_rt_q[tix]) begin
              if (oc_q == OC_BLOCKED) begin
                blk_q[tix]   <= 1'b1;
                woken_q[tix] <= 1'b0;
              end else begin
                tlvl_q[tix] <= rpt_lvl;
              end
            end
          end else if (func_q == FN_WAKE && tid_ok && in_use_q[tix] && blk_q[tix]
                       && !woken_q[tix]) begin
            woken_q[tix] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the sequencer and the output.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        func_q    <= func_e'(func_i);
        tid_q     <= task_id_i;
        rt_in_q   <= real_time_i;
        sl_q      <= start_level_i;
        oc_q      <= outcome_e'(outcome_i);
        cand_q    <= (last_id_q >= SW'(MAX_TASKS)) ? SW'(1) : last_id_q + SW'(1);
        k_q       <= '0;
        nblk_q    <= cnt_q[QBLK];
        res_ok_q  <= 1'b0;
        res_id_q  <= '0;
        res_lvl_q <= '0;
        res_swp_q <= 1'b0;
        res_mov_q <= '0;
      end
      S_SPAWN: begin
        if (k_q != SW'(MAX_TASKS)) begin
          if (!in_use_q[cix]) begin
            res_ok_q  <= 1'b1;
            res_id_q  <= cand_q;
            res_lvl_q <= rt_in_q ? '0 : sl_clamp;
          end else begin
            cand_q <= (cand_q == SW'(MAX_TASKS)) ? SW'(1) : cand_q + SW'(1);
            k_q    <= k_q + SW'(1);
          end
        end
      end
      S_BWAIT: begin
        k_q <= k_q + SW'(1);
        if (woken_q[bix]) res_mov_q <= res_mov_q + SW'(1);
      end
      S_SEL: begin
        if (cnt_q[QRT] != '0) begin
          res_lvl_q <= '0;
        end else if (lvl_found) begin
          res_lvl_q <= lvl_first;
        end else begin
          res_swp_q <= 1'b1;
        end
      end
      S_PWAIT: begin
        res_ok_q <= 1'b1;
        res_id_q <= rdata_q;
      end
      S_RPT: begin
        res_id_q <= SW'(tid_q);
        if (func_q == FN_REPORT && tid_ok && in_use_q[tix] && run_q[tix]) begin
          res_ok_q <= 1'b1;
          if (oc_q != OC_TERMINATED && oc_q != OC_BLOCKED && !is_rt_q[tix]) begin
            res_lvl_q <= rpt_lvl;
          end
        end else if (func_q == FN_WAKE && tid_ok && in_use_q[tix] && blk_q[tix]
                     && !woken_q[tix]) begin
          res_ok_q <= 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_ok_q  <= res_ok_q;
          out_id_q  <= 5'(res_id_q);
          out_lvl_q <= 3'(res_lvl_q);
          out_swp_q <= res_swp_q;
          out_mov_q <= 5'(res_mov_q);
          // The shifter scales the quantum by the served level.
          if (func_q == FN_DISPATCH && res_ok_q) begin
            out_quant_q <= (res_lvl_q == '0) ? base_q : base_q >> (res_lvl_q - LVW'(1));
          end else begin
            out_quant_q <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o   = (state_q == S_IDLE);
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign result_id_o   = out_id_q;
  assign level_o       = out_lvl_q;
  assign quantum_o     = out_quant_q;
  assign swapped_o     = out_swp_q;
  assign woken_moved_o = out_mov_q;

endmodule

/* hdl/mlfq_checker.sv */
module mlfq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        ok_o,
  input logic [4:0]  result_id_o,
  input logic [29:0] quantum_o,
  input logic        swapped_o,
  input logic [4:0]  woken_moved_o
);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_id_o)
      && $stable(quantum_o))
    else $error("result changed while stalled");

  // An accepted item occupies the sequencer for at least the next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // A quantum is only granted by a successful dispatch.
  a_quant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && quantum_o != 30'd0 |-> ok_o)
    else $error("quantum on refused item");

  // Woken tasks fill level one, so no swap can follow them.
  a_swap_moved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && swapped_o |-> woken_moved_o == 5'd0)
    else $error("swap after woken moves");

endmodule

bind mlfq_scheduler_active_expired mlfq_checker u_mlfq_checker (.*);

/* sim/mlfq_sched_checker.sv */
`timescale 1ns / 1ps

module mlfq_sched_checker import mlfq_pkg::*; #(
  parameter int MAX_TASKS = 18,
  parameter int LEVELS    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [29:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [4:0]  task_id_i,
  input  logic        real_time_i,
  input  logic [2:0]  start_level_i,
  input  logic [1:0]  outcome_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        ok_i,
  input  logic [4:0]  result_id_i,
  input  logic [2:0]  level_i,
  input  logic [29:0] quantum_i,
  input  logic        swapped_i,
  input  logic [4:0]  woken_moved_i,
  output int          err_cnt_o,
  output int          pending_o,
  output int          grant_cnt_o,
  output int          swap_cnt_o
);

  localparam int NQ = 2 + 2 * LEVELS;

  typedef struct packed {
    logic        ok;
    logic [4:0]  rid;
    logic [2:0]  lvl;
    logic [29:0] quant;
    logic        swp;
    logic [4:0]  moved;
  } sched_res_t;

  sched_res_t sched_q[$];

  // Shadow scheduler state; queues are kept as plain SystemVerilog queues.
  logic [29:0] slice_ns;
  bit          live[MAX_TASKS];
  bit          is_rt[MAX_TASKS];
  int          lvl_of[MAX_TASKS];
  bit          woken[MAX_TASKS];
  bit          running[MAX_TASKS];
  bit          blocked[MAX_TASKS];
  int          last_id;
  int          bank;
  int          runq[NQ][$];

  function automatic int lq(int b, int l);
    return 2 + b * LEVELS + (l - 1);
  endfunction

  task automatic sched_reset();
    slice_ns = QUANTUM_RESET;
    for (int i = 0; i < MAX_TASKS; i++) begin
      live[i] = 0; is_rt[i] = 0; lvl_of[i] = 0;
      woken[i] = 0; running[i] = 0; blocked[i] = 0;
    end
    for (int q = 0; q < NQ; q++) runq[q].delete();
    last_id = 0;
    bank = 0;
  endtask

  function automatic sched_res_t schedule_item(func_e fn, int tid, bit rt, int sl,
                                               outcome_e oc);
    sched_res_t r;
    int n, id, x, q, l;
    r = '0;
    case (fn)
      FN_SPAWN: begin
        for (int k = 1; k <= MAX_TASKS; k++) begin
          id = ((last_id + k - 1) % MAX_TASKS) + 1;
          x = id - 1;
          if (!live[x]) begin
            live[x] = 1; last_id = id;
            woken[x] = 0; running[x] = 0; blocked[x] = 0;
            if (rt) begin
              is_rt[x] = 1; lvl_of[x] = 0;
              runq[QRT].push_back(id);
            end else begin
              if (sl < 1) sl = 1;
              if (sl > LEVELS) sl = LEVELS;
              is_rt[x] = 0; lvl_of[x] = sl;
              runq[lq(bank, sl)].push_back(id);
            end
            r.ok = 1; r.rid = 5'(id); r.lvl = 3'(lvl_of[x]);
            break;
          end
        end
      end
      FN_DISPATCH: begin
        // One pass over the blocked queue: woken tasks go to active level one.
        n = runq[QBLK].size();
        for (int k = 0; k < n; k++) begin
          id = runq[QBLK].pop_front();
          x = id - 1;
          if (woken[x]) begin
            woken[x] = 0; blocked[x] = 0; lvl_of[x] = 1;
            runq[lq(bank, 1)].push_back(id);
            r.moved++;
          end else begin
            runq[QBLK].push_back(id);
          end
        end
        if (runq[QRT].size() != 0) begin
          id = runq[QRT].pop_front();
          running[id - 1] = 1;
          r.ok = 1; r.rid = 5'(id); r.quant = slice_ns;
        end else begin
          q = 0;
          for (int i = 1; i <= LEVELS && q == 0; i++)
            if (runq[lq(bank, i)].size() != 0) q = i;
          if (q == 0) begin
            bank ^= 1; r.swp = 1;
            for (int i = 1; i <= LEVELS && q == 0; i++)
              if (runq[lq(bank, i)].size() != 0) q = i;
          end
          if (q != 0) begin
            id = runq[lq(bank, q)].pop_front();
            running[id - 1] = 1;
            r.ok = 1; r.rid = 5'(id); r.lvl = 3'(q);
            r.quant = slice_ns >> (q - 1);
          end
        end
      end
      default: begin
        r.rid = 5'(tid);
        if (tid >= 1 && tid <= MAX_TASKS && live[tid - 1]) begin
          x = tid - 1;
          if (fn == FN_REPORT && running[x]) begin
            r.ok = 1; running[x] = 0;
            if (oc == OC_TERMINATED) begin
              live[x] = 0; woken[x] = 0; blocked[x] = 0;
            end else if (is_rt[x]) begin
              runq[QRT].push_back(tid);
            end else if (oc == OC_BLOCKED) begin
              blocked[x] = 1; woken[x] = 0;
              runq[QBLK].push_back(tid);
            end else begin
              l = (lvl_of[x] < 1) ? 1 : lvl_of[x];
              if (oc == OC_WHOLE) begin
                if (l < LEVELS) l++;
                runq[lq(bank ^ 1, l)].push_back(tid);
              end else begin
                runq[lq(bank, l)].push_back(tid);
              end
              lvl_of[x] = l; r.lvl = 3'(l);
            end
          end else if (fn == FN_WAKE && blocked[x] && !woken[x]) begin
            woken[x] = 1; r.ok = 1;
          end
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t e;
    if (!rst_ni) begin
      sched_reset();
      sched_q.delete();
      err_cnt_o   <= 0;
      grant_cnt_o <= 0;
      swap_cnt_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) slice_ns = cfg_data_i;
      if (out_valid_i && out_ready_i) begin
        if (sched_q.size() == 0) begin
          $error("result item with nothing expected");
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          e = sched_q.pop_front();
          if (e.ok != ok_i) $error("ok exp %0d got %0d", e.ok, ok_i);
          if (e.rid != result_id_i)
            $error("result_id exp %0d got %0d", e.rid, result_id_i);
          if (e.lvl != level_i) $error("level exp %0d got %0d", e.lvl, level_i);
          if (e.quant != quantum_i)
            $error("quantum exp %0d got %0d", e.quant, quantum_i);
          if (e.swp != swapped_i) $error("swapped exp %0d got %0d", e.swp, swapped_i);
          if (e.moved != woken_moved_i)
            $error("woken_moved exp %0d got %0d", e.moved, woken_moved_i);
          if (e != {ok_i, result_id_i, level_i, quantum_i, swapped_i, woken_moved_i})
            err_cnt_o <= err_cnt_o + 1;
          if (ok_i && e.quant != 0) grant_cnt_o <= grant_cnt_o + 1;
          if (swapped_i) swap_cnt_o <= swap_cnt_o + 1;
        end
      end
      if (in_valid_i && in_ready_i)
        sched_q.push_back(schedule_item(func_e'(func_i), int'(task_id_i), real_time_i,
                                        int'(start_level_i), outcome_e'(outcome_i)));
    end
  end

  assign pending_o = sched_q.size();

endmodule

/* sim/mlfq_scheduler_active_expired_tb.sv */
`timescale 1ns / 1ps

// Testbench top. It drives the task item channel and the quantum register
// port, and lets the receiver stall on its own pattern. Results are checked in
// mlfq_sched_checker, which reports a failure count back here.
module mlfq_scheduler_active_expired_tb;
  import mlfq_pkg::*;

  localparam int MAX_TASKS = 18;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [29:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [4:0]  task_id_i;
  logic        real_time_i;
  logic [2:0]  start_level_i;
  logic [1:0]  outcome_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        ok_o;
  logic [4:0]  result_id_o;
  logic [2:0]  level_o;
  logic [29:0] quantum_o;
  logic        swapped_o;
  logic [4:0]  woken_moved_o;

  int err_cnt, pending, grant_cnt, swap_cnt;
  int sent_cnt;
  bit stall_on;

  // Ids the stimulus believes are running, so reports usually hit a real task.
  int running_ids[$];

  mlfq_scheduler_active_expired #(.MAX_TASKS(MAX_TASKS), .LEVELS(4)) u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .func_i, .task_id_i, .real_time_i,
    .start_level_i, .outcome_i, .out_valid_o, .out_ready_i, .ok_o,
    .result_id_o, .level_o, .quantum_o, .swapped_o, .woken_moved_o
  );

  mlfq_sched_checker #(.MAX_TASKS(MAX_TASKS), .LEVELS(4)) u_chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .task_id_i, .real_time_i,
    .start_level_i, .outcome_i, .out_valid_i(out_valid_o), .out_ready_i,
    .ok_i(ok_o), .result_id_i(result_id_o), .level_i(level_o),
    .quantum_i(quantum_o), .swapped_i(swapped_o), .woken_moved_i(woken_moved_o),
    .err_cnt_o(err_cnt), .pending_o(pending), .grant_cnt_o(grant_cnt),
    .swap_cnt_o(swap_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver alternates between runs of always-ready and runs of random
  // stalls, so results are both taken at once and held under back pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_on    <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
      out_ready_i <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
    end
  end

  // Also track dispatched ids so reports target running tasks most of the time.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i && ok_o && quantum_o != 0)
      running_ids.push_back(int'(result_id_o));
  end

  // Present one item and hold it until the handshake completes.
  task automatic send_item(func_e fn, logic [4:0] tid, logic rt, logic [2:0] sl,
                           outcome_e oc);
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    task_id_i     <= tid;
    real_time_i   <= rt;
    start_level_i <= sl;
    outcome_i     <= oc;
    do @(posedge clk_i); while (!in_ready_o);
    sent_cnt++;
  endtask

  // Drop valid for a random gap, or not at all inside a burst.
  task automatic maybe_gap(ref int burst_left);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = int'($urandom_range(0, 20));
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // The block is already idle by the time its last result is out.
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_quantum(logic [29:0] val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // A report with a random outcome for a running task (usually), else any id.
  task automatic send_report();
    logic [4:0] tid;
    int idx;
    if (running_ids.size() != 0 && $urandom_range(0, 9) != 0) begin
      idx = int'($urandom_range(0, running_ids.size() - 1));
      tid = 5'(running_ids[idx]);
      running_ids.delete(idx);
    end else begin
      tid = 5'($urandom_range(0, 31));
    end
    send_item(FN_REPORT, tid, 1'($urandom), 3'($urandom),
              outcome_e'($urandom_range(0, 3)));
  endtask

  task automatic random_phase(int count);
    int burst_left;
    int pick;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 22)
        send_item(FN_SPAWN, 5'($urandom), 1'($urandom), 3'($urandom),
                  outcome_e'($urandom));
      else if (pick < 50)
        send_item(FN_DISPATCH, 5'($urandom), 1'($urandom), 3'($urandom),
                  outcome_e'($urandom));
      else if (pick < 82)
        send_report();
      else
        send_item(FN_WAKE, 5'($urandom_range(1, MAX_TASKS)), 1'($urandom),
                  3'($urandom), outcome_e'($urandom));
      maybe_gap(burst_left);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    func_i        = '0;
    task_id_i     = '0;
    real_time_i   = 1'b0;
    start_level_i = '0;
    outcome_i     = '0;
    sent_cnt      = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty dispatch swaps banks, bad ids, clamped start levels,
    // a full table and a report for a task that is not running.
    send_item(FN_DISPATCH, 5'd0, 1'b0, 3'd0, OC_TERMINATED);
    send_item(FN_REPORT, 5'd0, 1'b0, 3'd0, OC_PART);
    send_item(FN_WAKE, 5'd31, 1'b1, 3'd7, OC_WHOLE);
    send_item(FN_SPAWN, 5'd31, 1'b0, 3'd0, OC_PART);
    send_item(FN_SPAWN, 5'd0, 1'b0, 3'd7, OC_WHOLE);
    send_item(FN_SPAWN, 5'd0, 1'b1, 3'd2, OC_TERMINATED);
    for (int i = 0; i < MAX_TASKS - 2; i++)
      send_item(FN_SPAWN, 5'd0, 1'b0, 3'(i % 5), OC_TERMINATED);
    send_item(FN_REPORT, 5'd2, 1'b0, 3'd0, OC_PART);
    wait_drain();
    running_ids.delete();

    // Walk a few tasks through each outcome while varying the quantum.
    write_quantum(30'd1);
    random_phase(60);
    wait_drain();
    write_quantum(30'h3FFF_FFFF);
    random_phase(400);
    wait_drain();
    write_quantum(30'd1_000_000_000);
    random_phase(400);
    wait_drain();
    write_quantum(30'($urandom_range(1, 1_000_000_000)));
    random_phase(370);
    wait_drain();

    $display("Sent %0d task items; %0d grants with a quantum and %0d bank swaps seen.",
             sent_cnt, grant_cnt, swap_cnt);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
